[rtl/dtpw_pkg.sv]
// ----------------------------------------------------------------------------
// dtpw_pkg: shared types and constants of the depth-tested pixel writer
// Sizes of the color and depth stores, command format between the front and
// the back, and the operation, outcome and register codes.
// ----------------------------------------------------------------------------
package dtpw_pkg;

   // store geometry
   localparam int MAX_DIM     = 256;
   localparam int DEPTH_BITS  = 24;
   localparam int COORD_BITS  = $clog2(MAX_DIM);
   localparam int STORE_SIZE  = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS   = $clog2(STORE_SIZE);

   // field widths of the ports
   localparam int OPCODE_BITS    = 2;
   localparam int COORD_IN_BITS  = 16;
   localparam int IN_DEPTH_BITS  = 24;
   localparam int CHAN_BITS      = 8;
   localparam int COLOR_BITS     = 32;
   localparam int OUTCOME_BITS   = 2;
   localparam int DIM_BITS       = 9;
   localparam int CFG_INDEX_BITS = 2;
   localparam int CFG_DATA_BITS  = 32;

   // derived widths
   localparam int DIMC_BITS = COORD_BITS + 1;
   localparam int DIMW_BITS = (DIM_BITS > DIMC_BITS) ? DIM_BITS : DIMC_BITS;
   localparam int CMP_BITS  = (COORD_IN_BITS > DIMC_BITS) ? COORD_IN_BITS : DIMC_BITS;
   localparam int PROD_BITS = COORD_BITS + DIMC_BITS;
   localparam int ZW_BITS   = (IN_DEPTH_BITS > DEPTH_BITS) ? IN_DEPTH_BITS : DEPTH_BITS;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   // reset values of the registers
   localparam logic [DIM_BITS-1:0]   FRAME_DIM_RESET  = DIM_BITS'(256);
   localparam logic [COLOR_BITS-1:0] BACKGROUND_RESET = '0;

   // depth limits
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_LOW  = {1'b1, {(DEPTH_BITS-1){1'b0}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_HIGH = {1'b0, {(DEPTH_BITS-1){1'b1}}};

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_WRITE = 2'd0,
      OP_TEST  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [OUTCOME_BITS-1:0] {
      OUT_WRITTEN    = 2'd0,
      OUT_DEPTH_FAIL = 2'd1,
      OUT_OUTSIDE    = 2'd2,
      OUT_CLEARED    = 2'd3
   } outcome_type;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      REG_FRAME_WIDTH     = 2'd0,
      REG_FRAME_HEIGHT    = 2'd1,
      REG_BACKGROUND_RGBA = 2'd2
   } reg_index_type;

   // what the back has to do with a queued command
   typedef enum logic [1:0] {
      KIND_DROP  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_TEST  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                       kind;
      logic [ADDR_BITS-1:0]           addr;
      logic signed [DEPTH_BITS-1:0]   depth;
      logic [COLOR_BITS-1:0]          color;
   } cmd_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]   frame_width;
      logic [DIM_BITS-1:0]   frame_height;
      logic [COLOR_BITS-1:0] background_rgba;
   } cfg_type;

   // queue state as seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // dimension limited to the store size
   function automatic logic [DIMC_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] d);
      logic [DIMW_BITS-1:0] dw;
      dw = DIMW_BITS'(d);
      if (dw > DIMW_BITS'(MAX_DIM)) begin
         return DIMC_BITS'(MAX_DIM);
      end
      return DIMC_BITS'(dw);
   endfunction

   // fragment depth saturated to the stored depth range
   function automatic logic signed [DEPTH_BITS-1:0] sat_depth(
      input logic signed [IN_DEPTH_BITS-1:0] z);
      logic signed [ZW_BITS-1:0] zw;
      logic signed [ZW_BITS-1:0] lo;
      logic signed [ZW_BITS-1:0] hi;
      zw = ZW_BITS'(z);
      lo = ZW_BITS'(DEPTH_LOW);
      hi = ZW_BITS'(DEPTH_HIGH);
      if (zw < lo) begin
         return DEPTH_LOW;
      end
      if (zw > hi) begin
         return DEPTH_HIGH;
      end
      return DEPTH_BITS'(zw);
   endfunction

endpackage

[rtl/dtpw_if.sv]
// ----------------------------------------------------------------------------
// dtpw_if: channel interfaces of the depth-tested pixel writer
// Request channel (operation, coordinates, depth, color) and response channel
// (outcome), each a valid/ready channel with source and sink views.
// ----------------------------------------------------------------------------
interface dtpw_req_if;
   import dtpw_pkg::*;

   logic                            valid;
   logic                            ready;
   logic [OPCODE_BITS-1:0]          opcode;
   logic signed [COORD_IN_BITS-1:0] pixel_x;
   logic signed [COORD_IN_BITS-1:0] pixel_y;
   logic signed [IN_DEPTH_BITS-1:0] depth_value;
   logic [CHAN_BITS-1:0]            red;
   logic [CHAN_BITS-1:0]            green;
   logic [CHAN_BITS-1:0]            blue;
   logic [CHAN_BITS-1:0]            alpha;

   modport source (
      output valid, opcode, pixel_x, pixel_y, depth_value, red, green, blue, alpha,
      input  ready
   );
   modport sink (
      input  valid, opcode, pixel_x, pixel_y, depth_value, red, green, blue, alpha,
      output ready
   );
endinterface

interface dtpw_rsp_if;
   import dtpw_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OUTCOME_BITS-1:0] outcome;

   modport source (output valid, outcome, input ready);
   modport sink (input valid, outcome, output ready);
endinterface

[rtl/dtpw_front.sv]
// ----------------------------------------------------------------------------
// dtpw_front: request intake and classification
// Checks the coordinates against the active frame, forms the store address
// y * width + x, saturates the depth and pushes one command per beat.
// ----------------------------------------------------------------------------
module dtpw_front (
   input  dtpw_pkg::cfg_type          cfg,
   input  dtpw_pkg::queue_status_type q_status,
   input  logic                       init_busy,
   dtpw_req_if.sink                   req,
   output logic                       push,
   output dtpw_pkg::cmd_type          push_cmd
);
   import dtpw_pkg::*;

   logic [DIMC_BITS-1:0] width_c;
   logic [DIMC_BITS-1:0] height_c;
   logic                 x_ok;
   logic                 y_ok;
   logic [PROD_BITS-1:0] addr_full;

   // no intake while the store is swept after reset or the queue is full
   assign req.ready = ~q_status.full & ~init_busy;
   assign push      = req.valid & req.ready;

   // frame check and address
   always_comb begin
      width_c   = clamp_dim(cfg.frame_width);
      height_c  = clamp_dim(cfg.frame_height);
      x_ok      = ~req.pixel_x[COORD_IN_BITS-1]
                  & (CMP_BITS'($unsigned(req.pixel_x)) < CMP_BITS'(width_c));
      y_ok      = ~req.pixel_y[COORD_IN_BITS-1]
                  & (CMP_BITS'($unsigned(req.pixel_y)) < CMP_BITS'(height_c));
      addr_full = PROD_BITS'(req.pixel_y[COORD_BITS-1:0]) * PROD_BITS'(width_c)
                  + PROD_BITS'(req.pixel_x[COORD_BITS-1:0]);
   end

   // command build
   always_comb begin
      push_cmd.addr  = addr_full[ADDR_BITS-1:0];
      push_cmd.depth = sat_depth(req.depth_value);
      push_cmd.color = {req.red, req.green, req.blue, req.alpha};
      case (opcode_type'(req.opcode))
         OP_WRITE: begin
            push_cmd.kind = (x_ok & y_ok) ? KIND_WRITE : KIND_DROP;
         end
         OP_TEST: begin
            push_cmd.kind = (x_ok & y_ok) ? KIND_TEST : KIND_DROP;
         end
         OP_CLEAR: begin
            push_cmd.kind = KIND_CLEAR;
         end
         default: begin
            push_cmd.kind = KIND_DROP;
         end
      endcase
   end

endmodule

[rtl/dtpw_queue.sv]
// ----------------------------------------------------------------------------
// dtpw_queue: command queue between front and back
// Two-entry FIFO of classified commands so that intake and execution stall
// independently.
// ----------------------------------------------------------------------------
module dtpw_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  dtpw_pkg::cmd_type           push_cmd,
   input  logic                        pop,
   output dtpw_pkg::cmd_type           head_cmd,
   output dtpw_pkg::queue_status_type  q_status
);
   import dtpw_pkg::*;

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;

   assign head_cmd       = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/dtpw_back.sv]
// ----------------------------------------------------------------------------
// dtpw_back: command execution on the color and depth stores
// Sequencer that runs one command at a time: plain writes, depth-tested
// read-compare-write, drops and the clear sweep, and holds the outcome beat.
// ----------------------------------------------------------------------------
module dtpw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  dtpw_pkg::cfg_type           cfg,
   input  dtpw_pkg::queue_status_type  q_status,
   input  dtpw_pkg::cmd_type           head_cmd,
   output logic                        pop,
   output logic                        init_busy,
   dtpw_rsp_if.source                  rsp
);
   import dtpw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_TEST  = 3'b010,
      ST_CLEAR = 3'b100
   } state_type;

   // stores
   logic [COLOR_BITS-1:0]        color_mem [STORE_SIZE];
   logic signed [DEPTH_BITS-1:0] depth_mem [STORE_SIZE];

   state_type                    state_ff;
   state_type                    state_in;
   cmd_type                      cmd_ff;
   cmd_type                      cmd_in;
   logic [ADDR_BITS-1:0]         clr_idx_ff;
   logic [ADDR_BITS-1:0]         clr_idx_in;
   logic                         clr_rsp_ff;
   logic                         clr_rsp_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   outcome_type                  rsp_outcome_ff;
   outcome_type                  rsp_outcome_in;
   logic signed [DEPTH_BITS-1:0] depth_rd_ff;

   logic                         rd_en;
   logic                         color_we;
   logic                         depth_we;
   logic [ADDR_BITS-1:0]         wr_addr;
   logic [COLOR_BITS-1:0]        color_wd;
   logic signed [DEPTH_BITS-1:0] depth_wd;

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.outcome = rsp_outcome_ff;
   assign init_busy   = (state_ff == ST_CLEAR) & ~clr_rsp_ff;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      clr_idx_in     = clr_idx_ff;
      clr_rsp_in     = clr_rsp_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp.ready;
      rsp_outcome_in = rsp_outcome_ff;
      pop            = 1'b0;
      rd_en          = 1'b0;
      color_we       = 1'b0;
      depth_we       = 1'b0;
      wr_addr        = cmd_ff.addr;
      color_wd       = cmd_ff.color;
      depth_wd       = cmd_ff.depth;
      case (state_ff)
         ST_IDLE: begin
            // start the next command only with the result slot free
            if (~q_status.empty & ~rsp_valid_ff) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               case (head_cmd.kind)
                  KIND_WRITE: begin
                     color_we       = 1'b1;
                     wr_addr        = head_cmd.addr;
                     color_wd       = head_cmd.color;
                     rsp_valid_in   = 1'b1;
                     rsp_outcome_in = OUT_WRITTEN;
                  end
                  KIND_TEST: begin
                     rd_en    = 1'b1;
                     state_in = ST_TEST;
                  end
                  KIND_CLEAR: begin
                     clr_idx_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     rsp_valid_in   = 1'b1;
                     rsp_outcome_in = OUT_OUTSIDE;
                  end
               endcase
            end
         end
         ST_TEST: begin
            // stored depth nearer than the fragment: reject, ties write
            if (depth_rd_ff > cmd_ff.depth) begin
               rsp_outcome_in = OUT_DEPTH_FAIL;
            end else begin
               color_we       = 1'b1;
               depth_we       = 1'b1;
               rsp_outcome_in = OUT_WRITTEN;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_CLEAR: begin
            // the sweep after reset always uses the reset background
            color_we   = 1'b1;
            depth_we   = 1'b1;
            wr_addr    = clr_idx_ff;
            color_wd   = clr_rsp_ff ? cfg.background_rgba : BACKGROUND_RESET;
            depth_wd   = DEPTH_LOW;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == ADDR_BITS'(STORE_SIZE - 1)) begin
               state_in   = ST_IDLE;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = OUT_CLEARED;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers; reset starts the initial sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   // depth read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         depth_rd_ff <= depth_mem[head_cmd.addr];
      end
   end

   // write ports
   always_ff @(posedge clock) begin
      if (color_we) begin
         color_mem[wr_addr] <= color_wd;
      end
      if (depth_we) begin
         depth_mem[wr_addr] <= depth_wd;
      end
   end

endmodule

[rtl/depth_tested_pixel_writer.sv]
// ----------------------------------------------------------------------------
// depth_tested_pixel_writer: frame buffer with depth test
// Top level: configuration registers, request front, command queue and the
// execution back end with the color and depth stores.
// ----------------------------------------------------------------------------
// After reset the block sweeps both stores (color to the reset background of
// zero, depth to the most negative value), one entry per cycle, and holds req
// ready low meanwhile; configuration writes are taken during the sweep but do
// not change its color.
// Requests enter a two-entry queue and are executed one at a time by the
// back-end sequencer, which starts a command only when the response register
// is empty. A plain write or a dropped request is done as it leaves the queue;
// a depth-tested write does a registered depth read, then compare and write;
// and a clear sweeps the whole store.
// Out-of-frame coordinates and the unused opcode report outcome 2; a clear
// covers the whole store regardless of the active frame size.
// ----------------------------------------------------------------------------
module depth_tested_pixel_writer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [dtpw_pkg::CFG_INDEX_BITS-1:0]   csr_index,
   input  logic [dtpw_pkg::CFG_DATA_BITS-1:0]    csr_wr_data,
   dtpw_req_if.sink                              req_ch,
   dtpw_rsp_if.source                            rsp_ch
);
   import dtpw_pkg::*;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   queue_status_type q_status;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             push;
   logic             pop;
   logic             init_busy;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH: begin
               cfg_in.frame_width = csr_wr_data[DIM_BITS-1:0];
            end
            REG_FRAME_HEIGHT: begin
               cfg_in.frame_height = csr_wr_data[DIM_BITS-1:0];
            end
            REG_BACKGROUND_RGBA: begin
               cfg_in.background_rgba = csr_wr_data[COLOR_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width     <= FRAME_DIM_RESET;
         cfg_ff.frame_height    <= FRAME_DIM_RESET;
         cfg_ff.background_rgba <= BACKGROUND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dtpw_front u_front (
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .init_busy (init_busy),
      .req       (req_ch),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   dtpw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   dtpw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .init_busy (init_busy),
      .rsp       (rsp_ch)
   );

endmodule

[rtl/dtpw_checker.sv]
// ----------------------------------------------------------------------------
// dtpw_checker: port-level checks of the depth-tested pixel writer
// Tracks beats in flight from request to response and checks the response
// channel and the post-reset sweep as seen on the ports.
// ----------------------------------------------------------------------------
module dtpw_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   import dtpw_pkg::*;

   localparam int FLIGHT_MAX  = QUEUE_DEPTH + 1;
   localparam int FLIGHT_BITS = 3;

   logic                   req_beat;
   logic                   rsp_beat;
   logic [FLIGHT_BITS-1:0] flight_ff;
   logic [FLIGHT_BITS-1:0] flight_in;

   assign req_beat = req_valid & req_ready;
   assign rsp_beat = rsp_valid & rsp_ready;

   // requests accepted and not yet answered
   always_comb begin
      flight_in = flight_ff;
      if (req_beat & ~rsp_beat) begin
         flight_in = flight_ff + 1'b1;
      end else if (rsp_beat & ~req_beat) begin
         flight_in = flight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid & ~rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no response without an outstanding request
   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> flight_ff != '0)
      else $error("response without outstanding request");

   // queue plus the command in execution bound the beats in flight
   a_flight_bound: assert property (@(posedge clock) disable iff (reset)
      flight_ff <= FLIGHT_BITS'(FLIGHT_MAX))
      else $error("too many requests in flight");

   // the store sweep after reset holds intake off
   a_init_sweep: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> ~req_ready)
      else $error("request taken during the reset sweep");

endmodule

bind depth_tested_pixel_writer dtpw_checker u_dtpw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);

[verif/dtpw_outcome_checker.sv]
// ----------------------------------------------------------------------------
// dtpw_outcome_checker: outcome scoreboard of the depth-tested pixel writer
// Watches the register port and both channels, keeps its own color and depth
// stores, predicts the outcome of every accepted request beat and compares it
// with the response beats in order.
// ----------------------------------------------------------------------------
module dtpw_outcome_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [dtpw_pkg::CFG_INDEX_BITS-1:0] csr_index,
   input  logic [dtpw_pkg::CFG_DATA_BITS-1:0]  csr_wr_data,
   dtpw_req_if                                 req_mon,
   dtpw_rsp_if                                 rsp_mon,
   output int                                  error_count,
   output int                                  pending_count
);
   import dtpw_pkg::*;

   typedef struct {
      int          beat;
      outcome_type outcome;
   } outcome_entry_type;

   // shadow of the frame and the registers
   logic [COLOR_BITS-1:0]        color_mem [STORE_SIZE];
   logic signed [DEPTH_BITS-1:0] depth_mem [STORE_SIZE];
   logic [DIM_BITS-1:0]          width_q;
   logic [DIM_BITS-1:0]          height_q;
   logic [COLOR_BITS-1:0]        background_q;
   outcome_entry_type            predicted_outcomes [$];
   int                           beat_count;

   // whole store to background color and farthest depth
   function automatic void wipe_stores();
      for (int i = 0; i < STORE_SIZE; i++) begin
         color_mem[i] = background_q;
         depth_mem[i] = DEPTH_LOW;
      end
   endfunction

   function automatic int active_dim(input logic [DIM_BITS-1:0] d);
      return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
   endfunction

   // apply one request beat to the shadow frame, return its outcome
   function automatic outcome_type predict_outcome(
      input logic [OPCODE_BITS-1:0]          op,
      input logic signed [COORD_IN_BITS-1:0] px,
      input logic signed [COORD_IN_BITS-1:0] py,
      input logic signed [IN_DEPTH_BITS-1:0] pz,
      input logic [COLOR_BITS-1:0]           rgba);
      int w;
      int h;
      int x;
      int y;
      int z;
      int addr;
      w = active_dim(width_q);
      h = active_dim(height_q);
      x = int'(px);
      y = int'(py);
      z = int'(pz);
      if (op == OP_CLEAR) begin
         wipe_stores();
         return OUT_CLEARED;
      end
      if (op != OP_WRITE && op != OP_TEST) begin
         return OUT_OUTSIDE;
      end
      if (x < 0 || x >= w || y < 0 || y >= h) begin
         return OUT_OUTSIDE;
      end
      addr = y * w + x;
      if (op == OP_TEST) begin
         // fragment depth limited to what the depth store can hold
         if (z < int'(DEPTH_LOW)) begin
            z = int'(DEPTH_LOW);
         end
         if (z > int'(DEPTH_HIGH)) begin
            z = int'(DEPTH_HIGH);
         end
         // ties pass, larger is nearer
         if (int'(depth_mem[addr]) > z) begin
            return OUT_DEPTH_FAIL;
         end
         depth_mem[addr] = DEPTH_BITS'(z);
      end
      color_mem[addr] = rgba;
      return OUT_WRITTEN;
   endfunction

   // register writes, request beats and response beats, in that order
   always @(posedge clock) begin
      outcome_entry_type entry;
      outcome_type       seen;
      if (reset) begin
         width_q      = FRAME_DIM_RESET;
         height_q     = FRAME_DIM_RESET;
         background_q = BACKGROUND_RESET;
         wipe_stores();
         predicted_outcomes.delete();
         error_count  = 0;
         beat_count   = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_FRAME_WIDTH:     width_q = csr_wr_data[DIM_BITS-1:0];
               REG_FRAME_HEIGHT:    height_q = csr_wr_data[DIM_BITS-1:0];
               REG_BACKGROUND_RGBA: background_q = csr_wr_data[COLOR_BITS-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            entry.beat    = beat_count;
            entry.outcome = predict_outcome(req_mon.opcode, req_mon.pixel_x,
                                            req_mon.pixel_y, req_mon.depth_value,
                                            {req_mon.red, req_mon.green,
                                             req_mon.blue, req_mon.alpha});
            predicted_outcomes.push_back(entry);
            beat_count++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = outcome_type'(rsp_mon.outcome);
            if (predicted_outcomes.size() == 0) begin
               error_count++;
               $display("%0t: response beat with outcome %s (%b) and no request pending",
                        $time, seen.name(), rsp_mon.outcome);
            end else begin
               entry = predicted_outcomes.pop_front();
               if (rsp_mon.outcome !== entry.outcome) begin
                  error_count++;
                  $display("%0t: request beat %0d: expected outcome %s, got %s (%b)",
                           $time, entry.beat, entry.outcome.name(), seen.name(),
                           rsp_mon.outcome);
               end
            end
         end
      end
      pending_count = predicted_outcomes.size();
   end

endmodule

[verif/depth_tested_pixel_writer_tb.sv]
// ----------------------------------------------------------------------------
// depth_tested_pixel_writer_tb: testbench of the depth-tested pixel writer
// Directed beats on frame edges, depth ties and odd frame sizes, then random
// beats over nine frame settings under three idle patterns; the outcome
// checker predicts and compares every response beat.
// ----------------------------------------------------------------------------
module depth_tested_pixel_writer_tb;
   import dtpw_pkg::*;

   localparam int CLOCK_HIGH   = 6;
   localparam int CLOCK_LOW    = 6;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 2_500_000;
   localparam int SETTLE_TICKS = 16;
   localparam int CHUNK_COUNT  = 9;
   localparam int CHUNK_BEATS  = 172;
   // opcode the block does not define
   localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CFG_INDEX_BITS-1:0] csr_index;
   logic [CFG_DATA_BITS-1:0]  csr_wr_data;
   int                        error_count;
   int                        pending_count;
   int                        cycle_count;
   int                        send_idle_pct = 0;
   int                        recv_idle_pct = 0;
   int                        frame_w;
   int                        frame_h;
   int                        op_tally [4] = '{default: 0};

   dtpw_req_if req_ch();
   dtpw_rsp_if rsp_ch();

   depth_tested_pixel_writer u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   dtpw_outcome_checker u_outcome_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #CLOCK_LOW clock = 1'b1;
      #CLOCK_HIGH clock = 1'b0;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_count);
      $display("tb: failure");
      $finish;
   end

   // response side stalls
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // one request beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [OPCODE_BITS-1:0] op, input int x, input int y,
                            input int z, input logic [COLOR_BITS-1:0] rgba);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.pixel_x     <= COORD_IN_BITS'(x);
      req_ch.pixel_y     <= COORD_IN_BITS'(y);
      req_ch.depth_value <= IN_DEPTH_BITS'(z);
      {req_ch.red, req_ch.green, req_ch.blue, req_ch.alpha} <= rgba;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      op_tally[op]++;
   endtask

   // stop sending and let every pending response come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
   endtask

   // width, height and background; junk above the 9-bit size fields
   task automatic set_frame(input int w, input int h, input logic [COLOR_BITS-1:0] bg);
      logic [CFG_DATA_BITS-1:0] word;
      word = $urandom;
      word[DIM_BITS-1:0] = DIM_BITS'(w);
      csr_wr_en   <= 1'b1;
      csr_index   <= REG_FRAME_WIDTH;
      csr_wr_data <= word;
      @(negedge clock);
      word = $urandom;
      word[DIM_BITS-1:0] = DIM_BITS'(h);
      csr_index   <= REG_FRAME_HEIGHT;
      csr_wr_data <= word;
      @(negedge clock);
      csr_index   <= REG_BACKGROUND_RGBA;
      csr_wr_data <= bg;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      frame_w = (w > MAX_DIM) ? MAX_DIM : w;
      frame_h = (h > MAX_DIM) ? MAX_DIM : h;
   endtask

   // coordinate inside a frame side; big frames mostly hit the corners
   function automatic int inside_coord(input int n);
      if (n > 8 && $urandom_range(3) != 0) begin
         return ($urandom_range(1) == 1) ? int'($urandom_range(3))
                                         : n - 1 - int'($urandom_range(3));
      end
      return int'($urandom_range(n - 1));
   endfunction

   task automatic send_random_beat();
      int                     pick;
      int                     x;
      int                     y;
      int                     z;
      logic [OPCODE_BITS-1:0] op;
      pick = $urandom_range(99);
      op = ($urandom_range(9) < 3) ? OP_WRITE : OP_TEST;
      // depth mostly in a narrow band so ties and failed tests are common
      case ($urandom_range(9))
         0:       z = $urandom;
         1:       z = ($urandom_range(1) == 1) ? int'(DEPTH_LOW) : int'(DEPTH_HIGH);
         default: z = int'($urandom_range(6)) - 3;
      endcase
      if (pick < 4) begin
         op = OP_UNUSED;
         x = $urandom;
         y = $urandom;
      end else if (pick < 10) begin
         // anywhere in the coordinate space
         x = $urandom;
         y = $urandom;
      end else if (pick < 15) begin
         // just past one of the frame edges
         x = inside_coord(frame_w);
         y = inside_coord(frame_h);
         case ($urandom_range(3))
            0:       x = frame_w;
            1:       x = -1;
            2:       y = frame_h;
            default: y = -1;
         endcase
      end else begin
         x = inside_coord(frame_w);
         y = inside_coord(frame_h);
      end
      send_beat(op, x, y, z, $urandom);
   endtask

   initial begin
      int  w;
      int  h;
      bit  wipe;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = REG_FRAME_WIDTH;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_WRITE;
      req_ch.pixel_x     = '0;
      req_ch.pixel_y     = '0;
      req_ch.depth_value = '0;
      req_ch.red         = '0;
      req_ch.green       = '0;
      req_ch.blue        = '0;
      req_ch.alpha       = '0;
      frame_w            = MAX_DIM;
      frame_h            = MAX_DIM;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: full frame after reset, corners, depth ties and edges
      send_beat(OP_WRITE, 0, 0, 0, 32'h0000_0000);
      send_beat(OP_WRITE, 255, 255, 0, 32'hFFFF_FFFF);
      send_beat(OP_TEST, 255, 255, int'(DEPTH_LOW), 32'h1234_5678);
      send_beat(OP_TEST, 255, 255, int'(DEPTH_HIGH), 32'h89AB_CDEF);
      send_beat(OP_TEST, 255, 255, int'(DEPTH_HIGH), 32'h5A5A_A5A5);
      send_beat(OP_TEST, 255, 255, int'(DEPTH_HIGH) - 1, 32'hDEAD_0001);
      // a plain write must leave the stored depth alone
      send_beat(OP_WRITE, 255, 255, int'(DEPTH_LOW), 32'h0F0F_F0F0);
      send_beat(OP_TEST, 255, 255, int'(DEPTH_HIGH) - 1, 32'hDEAD_0002);
      send_beat(OP_WRITE, 256, 0, 0, 32'h0102_0304);
      send_beat(OP_TEST, 0, 256, 0, 32'h0506_0708);
      send_beat(OP_WRITE, -1, 0, 0, 32'h090A_0B0C);
      send_beat(OP_TEST, 0, -32768, 0, 32'h0D0E_0F10);
      send_beat(OP_WRITE, 32767, 32767, 0, 32'h1112_1314);
      send_beat(OP_UNUSED, 1, 1, 0, 32'h1516_1718);

      // zero width: nothing is inside
      wait_drained();
      set_frame(0, 5, 32'hFFFF_FFFF);
      send_beat(OP_WRITE, 0, 0, 0, 32'hAAAA_5555);
      send_beat(OP_TEST, 0, 0, int'(DEPTH_HIGH), 32'h5555_AAAA);

      // width above the store size is limited; zero height
      wait_drained();
      set_frame(300, 0, 32'hFFFF_FFFF);
      send_beat(OP_WRITE, 255, 0, 0, 32'h1357_9BDF);
      wait_drained();
      set_frame(511, 1, 32'hFFFF_FFFF);
      send_beat(OP_WRITE, 299, 0, 0, 32'h2468_ACE0);
      send_beat(OP_TEST, 255, 0, 7, 32'hFEDC_BA98);

      // resize then clear; clear ignores its other fields
      wait_drained();
      set_frame(3, 2, 32'hFFFF_FFFF);
      send_beat(OP_CLEAR, 32767, -1, int'(DEPTH_HIGH), 32'h7654_3210);
      send_beat(OP_TEST, 2, 1, int'(DEPTH_LOW), 32'h0000_00FF);
      send_beat(OP_TEST, 2, 1, int'(DEPTH_LOW), 32'hFF00_0000);

      // narrower without a clear: old entries read back at new positions
      wait_drained();
      set_frame(2, 2, 32'h0000_0000);
      send_beat(OP_TEST, 0, 1, int'(DEPTH_LOW), 32'hC0FF_EE00);
      send_beat(OP_TEST, 1, 0, int'(DEPTH_LOW) + 1, 32'h00C0_FFEE);

      // random: three idle patterns, three frame settings each
      for (int c = 0; c < CHUNK_COUNT; c++) begin
         case (c)
            0:       begin w = 1;   h = 1;   wipe = 1'b1; end
            1:       begin w = 4;   h = 4;   wipe = 1'b0; end
            2:       begin w = 5;   h = 3;   wipe = 1'b0; end
            3:       begin w = 256; h = 256; wipe = 1'b1; end
            4:       begin w = 511; h = 2;   wipe = 1'b0; end
            5:       begin w = 7;   h = 6;   wipe = 1'b0; end
            6:       begin w = 3;   h = 8;   wipe = 1'b1; end
            7:       begin w = 2;   h = 2;   wipe = 1'b0; end
            default: begin w = 16;  h = 9;   wipe = 1'b0; end
         endcase
         // registers change only with nothing in flight
         wait_drained();
         case (c / 3)
            0:       begin send_idle_pct = 22; recv_idle_pct = 45; end
            1:       begin send_idle_pct = 45; recv_idle_pct = 22; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         set_frame(w, h, $urandom);
         if (wipe) begin
            send_beat(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
         end
         repeat (CHUNK_BEATS) send_random_beat();
      end

      wait_drained();
      repeat (SETTLE_TICKS) @(negedge clock);
      $display("summary: %0d plain, %0d depth-tested, %0d clear, %0d unused-opcode beats",
               op_tally[OP_WRITE], op_tally[OP_TEST], op_tally[OP_CLEAR],
               op_tally[OP_UNUSED]);
      $display("summary: frame sizes from 0 to 511 wide, stalls on either side and none");
      if (error_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d responses never arrived", error_count, pending_count);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
